/* design/owrs_pkg.sv */
// Shared types and constants of the 1-Wire ROM search unit.
// Depends on nothing; the input register, engine, result register, top and testbench import it.
`timescale 1ns / 1ps

package owrs_pkg;

  // Operation codes of an input word
  localparam logic [2:0] OP_START        = 3'd0;
  localparam logic [2:0] OP_BIT_PAIR     = 3'd1;
  localparam logic [2:0] OP_BUS_ERROR    = 3'd2;
  localparam logic [2:0] OP_TARGET_SETUP = 3'd3;
  localparam logic [2:0] OP_RESET_SEARCH = 3'd4;
  localparam logic [2:0] OP_START_VERIFY = 3'd5;

  // Event codes of a result word
  localparam logic [1:0] EV_CMD  = 2'd0;
  localparam logic [1:0] EV_DIR  = 2'd1;
  localparam logic [1:0] EV_DONE = 2'd2;
  localparam logic [1:0] EV_ACK  = 2'd3;

  // Search commands and search bookkeeping constants
  localparam logic [7:0] CMD_ALARM    = 8'hEC;
  localparam logic [7:0] CMD_NORMAL   = 8'hF0;
  localparam logic [6:0] TARGET_DISC  = 7'h40;
  localparam logic [6:0] END_INDEX    = 7'd65;
  localparam logic [6:0] FAMILY_LIMIT = 7'd9;
  localparam logic [7:0] CRC_POLY     = 8'h8C;

  // One input word
  typedef struct packed {
    logic [2:0] operation;
    logic       alarm_only;
    logic       present;
    logic       id_bit;
    logic       cmp_bit;
    logic [7:0] family_id;
  } owrs_item_t;

  // One result word
  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  command_byte;
    logic        direction;
    logic        found;
    logic [63:0] rom_id;
    logic        last_device;
    logic [3:0]  family_discrepancy;
  } owrs_result_t;

endpackage

/* design/owrs_if.sv */
// Valid/ready channel interfaces for input and result words of the search unit.
// Depends on owrs_pkg for nothing but shares its field widths.
`timescale 1ns / 1ps

interface owrs_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic       alarm_only;
  logic       present;
  logic       id_bit;
  logic       cmp_bit;
  logic [7:0] family_id;

  modport source (
    output valid, operation, alarm_only, present, id_bit, cmp_bit, family_id,
    input  ready
  );
  modport sink (
    input  valid, operation, alarm_only, present, id_bit, cmp_bit, family_id,
    output ready
  );
endinterface

interface owrs_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  command_byte;
  logic        direction;
  logic        found;
  logic [63:0] rom_id;
  logic        last_device;
  logic [3:0]  family_discrepancy;

  modport source (
    output valid, event_res, command_byte, direction, found, rom_id, last_device,
           family_discrepancy,
    input  ready
  );
  modport sink (
    input  valid, event_res, command_byte, direction, found, rom_id, last_device,
           family_discrepancy,
    output ready
  );
endinterface

/* design/owrs_in_reg.sv */
// Input register of the search unit: captures one word and holds it until the engine takes it.
// Depends on owrs_pkg and owrs_item_if.
`timescale 1ns / 1ps

module owrs_in_reg
  import owrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  owrs_item_if.sink   req_i,
  input  logic        take_i,
  output logic        valid_o,
  output owrs_item_t  item_o
);

  logic       valid_q;
  owrs_item_t item_q;

  // Accept a new word when empty or when the held word leaves this cycle
  assign req_i.ready = !valid_q || take_i;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      item_q.operation  <= req_i.operation;
      item_q.alarm_only <= req_i.alarm_only;
      item_q.present    <= req_i.present;
      item_q.id_bit     <= req_i.id_bit;
      item_q.cmp_bit    <= req_i.cmp_bit;
      item_q.family_id  <= req_i.family_id;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* design/owrs_engine.sv */
// Search engine: ROM register, discrepancy bookkeeping, CRC8 and verify save/restore.
// Depends on owrs_pkg; one word is processed per advance in a single combinational pass.
`timescale 1ns / 1ps

module owrs_engine
  import owrs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         advance_i,
  input  owrs_item_t   item_i,
  output owrs_result_t result_o
);

  // Update a CRC8 (reflected 0x8C) with one byte
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [63:0] rom_q, rom_d;
  logic [6:0]  last_disc_q, last_disc_d;
  logic        last_dev_q, last_dev_d;
  logic [3:0]  last_fam_q, last_fam_d;
  logic [6:0]  bit_index_q, bit_index_d;
  logic [6:0]  last_zero_q, last_zero_d;
  logic [7:0]  crc_q, crc_d;
  logic        searching_q, searching_d;
  logic        verifying_q, verifying_d;
  logic [63:0] saved_rom_q, saved_rom_d;
  logic [11:0] saved_flags_q, saved_flags_d;

  logic       conc;
  logic       compl;
  logic       ok;
  logic       dir;
  logic [5:0] pos;
  logic [1:0] ev;
  logic [7:0] cmd;

  // Work out the next state and the result word for the held input word
  always_comb begin
    rom_d         = rom_q;
    last_disc_d   = last_disc_q;
    last_dev_d    = last_dev_q;
    last_fam_d    = last_fam_q;
    bit_index_d   = bit_index_q;
    last_zero_d   = last_zero_q;
    crc_d         = crc_q;
    searching_d   = searching_q;
    verifying_d   = verifying_q;
    saved_rom_d   = saved_rom_q;
    saved_flags_d = saved_flags_q;
    conc  = 1'b0;
    compl = 1'b0;
    ok    = 1'b0;
    dir   = 1'b0;
    ev    = EV_ACK;
    cmd   = 8'h00;
    pos   = 6'(bit_index_q - 7'd1);

    case (item_i.operation)
      OP_START, OP_START_VERIFY: begin
        // Abandon a running verify first
        if (verifying_d) begin
          rom_d       = saved_rom_d;
          last_disc_d = saved_flags_d[6:0];
          last_dev_d  = saved_flags_d[7];
          last_fam_d  = saved_flags_d[11:8];
          verifying_d = 1'b0;
        end
        if (item_i.operation == OP_START_VERIFY) begin
          saved_rom_d   = rom_d;
          saved_flags_d = {last_fam_d, last_dev_d, last_disc_d};
          last_disc_d   = TARGET_DISC;
          last_dev_d    = 1'b0;
          last_fam_d    = 4'd0;
          verifying_d   = 1'b1;
        end
        bit_index_d = 7'd1;
        last_zero_d = 7'd0;
        crc_d       = 8'h00;
        if (last_dev_d || !item_i.present) begin
          ev   = EV_DONE;
          conc = 1'b1;
        end else begin
          searching_d = 1'b1;
          ev          = EV_CMD;
          cmd = (item_i.alarm_only && item_i.operation == OP_START) ? CMD_ALARM : CMD_NORMAL;
        end
      end
      OP_BIT_PAIR: begin
        if (searching_q) begin
          if (item_i.id_bit && item_i.cmp_bit) begin
            // Nobody answered
            ev   = EV_DONE;
            conc = 1'b1;
          end else begin
            if (item_i.id_bit != item_i.cmp_bit) begin
              dir = item_i.id_bit;
            end else begin
              // Discrepancy: follow the previous path, take one at the last turn
              if (bit_index_q < last_disc_q) begin
                dir = rom_q[pos];
              end else begin
                dir = (bit_index_q == last_disc_q);
              end
              if (!dir) begin
                last_zero_d = bit_index_q;
                if (bit_index_q < FAMILY_LIMIT) begin
                  last_fam_d = bit_index_q[3:0];
                end
              end
            end
            rom_d[pos] = dir;
            if (bit_index_q[2:0] == 3'd0) begin
              crc_d = crc_byte(crc_q, rom_d[{pos[5:3], 3'b000} +: 8]);
            end
            bit_index_d = 7'(bit_index_q + 7'd1);
            if (bit_index_d >= END_INDEX) begin
              ev    = EV_DONE;
              conc  = 1'b1;
              compl = 1'b1;
            end else begin
              ev = EV_DIR;
            end
          end
        end
      end
      OP_BUS_ERROR: begin
        if (searching_q) begin
          ev   = EV_DONE;
          conc = 1'b1;
        end
      end
      OP_TARGET_SETUP: begin
        last_disc_d = TARGET_DISC;
        last_dev_d  = 1'b0;
        last_fam_d  = 4'd0;
        rom_d       = {56'd0, item_i.family_id};
        searching_d = 1'b0;
        verifying_d = 1'b0;
      end
      OP_RESET_SEARCH: begin
        last_disc_d = 7'd0;
        last_dev_d  = 1'b0;
        last_fam_d  = 4'd0;
        rom_d       = 64'd0;
        searching_d = 1'b0;
        verifying_d = 1'b0;
      end
      default: begin
        ev = EV_ACK;
      end
    endcase

    // Close the search: check CRC and family, settle flags, end a verify
    if (conc) begin
      ok          = compl && (crc_d == 8'h00);
      searching_d = 1'b0;
      if (ok) begin
        last_disc_d = last_zero_d;
        if (last_zero_d == 7'd0) begin
          last_dev_d = 1'b1;
        end
      end
      if (!ok || rom_d[7:0] == 8'h00) begin
        last_disc_d = 7'd0;
        last_dev_d  = 1'b0;
        last_fam_d  = 4'd0;
        ok          = 1'b0;
      end
      if (verifying_d) begin
        ok          = ok && (rom_d == saved_rom_d);
        rom_d       = saved_rom_d;
        last_disc_d = saved_flags_d[6:0];
        last_dev_d  = saved_flags_d[7];
        last_fam_d  = saved_flags_d[11:8];
        verifying_d = 1'b0;
      end
    end
  end

  // Commit state when the word moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q         <= 64'd0;
      last_disc_q   <= 7'd0;
      last_dev_q    <= 1'b0;
      last_fam_q    <= 4'd0;
      bit_index_q   <= 7'd1;
      last_zero_q   <= 7'd0;
      crc_q         <= 8'h00;
      searching_q   <= 1'b0;
      verifying_q   <= 1'b0;
      saved_rom_q   <= 64'd0;
      saved_flags_q <= 12'd0;
    end else if (advance_i) begin
      rom_q         <= rom_d;
      last_disc_q   <= last_disc_d;
      last_dev_q    <= last_dev_d;
      last_fam_q    <= last_fam_d;
      bit_index_q   <= bit_index_d;
      last_zero_q   <= last_zero_d;
      crc_q         <= crc_d;
      searching_q   <= searching_d;
      verifying_q   <= verifying_d;
      saved_rom_q   <= saved_rom_d;
      saved_flags_q <= saved_flags_d;
    end
  end

  assign result_o.event_res          = ev;
  assign result_o.command_byte       = cmd;
  assign result_o.direction          = dir;
  assign result_o.found              = ok;
  assign result_o.rom_id             = rom_d;
  assign result_o.last_device        = last_dev_d;
  assign result_o.family_discrepancy = last_fam_d;

  // A running search always points at one of the 64 ROM bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    searching_q |-> (bit_index_q >= 7'd1 && bit_index_q <= 7'd64))
    else $error("bit index out of range during search");

  // A verify only lives inside a running search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    verifying_q |-> searching_q)
    else $error("verify active without a search");

  // The family discrepancy never leaves the family byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_fam_q <= 4'd8)
    else $error("family discrepancy beyond family byte");

  // Last device is only flagged once no discrepancy is left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_dev_q |-> (last_disc_q == 7'd0))
    else $error("last device flagged with open discrepancy");

endmodule

/* design/owrs_out_reg.sv */
// Result register of the search unit: holds one result word until the sink takes it.
// Depends on owrs_pkg and owrs_result_if.
`timescale 1ns / 1ps

module owrs_out_reg
  import owrs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  owrs_result_t  result_i,
  output logic          room_o,
  owrs_result_if.source rsp_o
);

  logic         valid_q;
  owrs_result_t result_q;

  // Free when empty or when the held word is taken this cycle
  assign room_o = !valid_q || rsp_o.ready;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (room_o) begin
      valid_q <= load_i;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign rsp_o.valid              = valid_q;
  assign rsp_o.event_res          = result_q.event_res;
  assign rsp_o.command_byte       = result_q.command_byte;
  assign rsp_o.direction          = result_q.direction;
  assign rsp_o.found              = result_q.found;
  assign rsp_o.rom_id             = result_q.rom_id;
  assign rsp_o.last_device        = result_q.last_device;
  assign rsp_o.family_discrepancy = result_q.family_discrepancy;

  // A command event always carries one of the two search commands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && result_q.event_res == EV_CMD) |->
      (result_q.command_byte == CMD_ALARM || result_q.command_byte == CMD_NORMAL))
    else $error("command event without a search command");

endmodule

/* design/one_wire_rom_search_unit.sv */
// 1-Wire ROM search unit: it returns exactly one result word per input word, passing each
// from the input register through the engine into the result register. It takes one word
// per cycle while the sink is ready, set by the single engine pass between the two registers;
// a stalled sink holds the result register and, once the input register is full too, drops
// ready. Bus timing (reset, bit slots) is left to the caller; this unit only decides command
// bytes and direction bits and tracks the search state. No clearing pass is needed after
// reset.
// Depends on owrs_pkg, owrs_if, owrs_in_reg, owrs_engine and owrs_out_reg.
`timescale 1ns / 1ps

module one_wire_rom_search_unit
  import owrs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  owrs_item_if.sink     req_i,
  owrs_result_if.source rsp_o
);

  logic         in_valid;
  owrs_item_t   item;
  owrs_result_t result;
  logic         room;
  logic         advance;

  // Move the held word through the engine when the result register has room
  assign advance = in_valid && room;

  owrs_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .take_i  (advance),
    .valid_o (in_valid),
    .item_o  (item)
  );

  owrs_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .result_o  (result)
  );

  owrs_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result),
    .room_o   (room),
    .rsp_o    (rsp_o)
  );

endmodule

/* dv/one_wire_rom_search_unit_tb.sv */
// Self-checking testbench for the 1-Wire ROM search unit: directed table, then simulated buses.
// Depends on owrs_pkg, owrs_if and one_wire_rom_search_unit from the design folder.
`timescale 1ns / 1ps

module one_wire_rom_search_unit_tb;
  import owrs_pkg::*;

  // Operation codes the block treats as no-ops
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int N_ITEMS     = 1100;
  localparam int PHASE_LEN   = 200;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    owrs_item_t   w;
    logic         typed;
    owrs_result_t r;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  // Sender and receiver drive registers, routed onto the channels
  logic       src_vld  = 1'b0;
  owrs_item_t src_word = '0;
  logic       sink_rdy = 1'b0;
  int         stall_left = 0;
  bit         idle_on    = 1'b1;

  owrs_item_if   item_bus ();
  owrs_result_if res_bus ();

  assign item_bus.valid      = src_vld;
  assign item_bus.operation  = src_word.operation;
  assign item_bus.alarm_only = src_word.alarm_only;
  assign item_bus.present    = src_word.present;
  assign item_bus.id_bit     = src_word.id_bit;
  assign item_bus.cmp_bit    = src_word.cmp_bit;
  assign item_bus.family_id  = src_word.family_id;
  assign res_bus.ready       = sink_rdy;

  one_wire_rom_search_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (item_bus),
    .rsp_o  (res_bus)
  );

  // Search state mirrored by the predictor
  logic [63:0] rom_img;
  logic [6:0]  disc_pos;
  logic        last_dev;
  logic [3:0]  fam_disc;
  logic [6:0]  bit_pos;
  logic [6:0]  zero_pos;
  logic [7:0]  crc_run;
  logic        in_search;
  logic        in_verify;
  logic [63:0] save_rom;
  logic [11:0] save_flags;

  owrs_result_t expected_q [$];
  stim_row_t    directed_rows [$];
  logic [63:0]  devices [$];
  owrs_result_t got_res;
  owrs_result_t want_res;
  int           n_bad     = 0;
  int           n_counted = 0;
  int           n_cycles  = 0;

  // Clock: 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts while idling is on
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      sink_rdy   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 99) < 12) begin
      sink_rdy   <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      sink_rdy <= 1'b1;
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && sink_rdy) begin
      got_res.event_res          = res_bus.event_res;
      got_res.command_byte       = res_bus.command_byte;
      got_res.direction          = res_bus.direction;
      got_res.found              = res_bus.found;
      got_res.rom_id             = res_bus.rom_id;
      got_res.last_device        = res_bus.last_device;
      got_res.family_discrepancy = res_bus.family_discrepancy;
      if (expected_q.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("unexpected result word: ev=%0d rom=%h", got_res.event_res, got_res.rom_id);
      end else begin
        want_res = expected_q.pop_front();
        if (got_res.event_res !== want_res.event_res ||
            got_res.command_byte !== want_res.command_byte ||
            got_res.direction !== want_res.direction ||
            got_res.found !== want_res.found ||
            got_res.rom_id !== want_res.rom_id ||
            got_res.last_device !== want_res.last_device ||
            got_res.family_discrepancy !== want_res.family_discrepancy) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS)
            $display("mismatch: exp ev=%0d cmd=%h dir=%b fnd=%b rom=%h dev=%b fd=%0d | got ev=%0d cmd=%h dir=%b fnd=%b rom=%h dev=%b fd=%0d",
                     want_res.event_res, want_res.command_byte, want_res.direction,
                     want_res.found, want_res.rom_id, want_res.last_device,
                     want_res.family_discrepancy, got_res.event_res, got_res.command_byte,
                     got_res.direction, got_res.found, got_res.rom_id, got_res.last_device,
                     got_res.family_discrepancy);
        end
      end
    end
  end

  // Reflected CRC8 over one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void restore_saved();
    rom_img   = save_rom;
    disc_pos  = save_flags[6:0];
    last_dev  = save_flags[7];
    fam_disc  = save_flags[11:8];
    in_verify = 1'b0;
  endfunction

  // End the running search; return the found flag
  function automatic logic close_search(input logic complete);
    logic ok;
    ok = complete && crc_run == 8'h00;
    in_search = 1'b0;
    if (ok) begin
      disc_pos = zero_pos;
      if (disc_pos == 7'd0) last_dev = 1'b1;
    end
    if (!ok || rom_img[7:0] == 8'h00) begin
      disc_pos = '0;
      last_dev = 1'b0;
      fam_disc = '0;
      ok       = 1'b0;
    end
    if (in_verify) begin
      ok = ok && rom_img == save_rom;
      restore_saved();
    end
    return ok;
  endfunction

  // Advance the mirrored search state by one input word and form its result word
  task automatic predict_word(input owrs_item_t w, output owrs_result_t r);
    logic [5:0] pos;
    logic       dir;
    logic       alarm;
    r           = '0;
    r.event_res = EV_ACK;
    alarm       = w.alarm_only;
    case (w.operation)
      OP_START, OP_START_VERIFY: begin
        if (in_verify) restore_saved();
        if (w.operation == OP_START_VERIFY) begin
          save_rom   = rom_img;
          save_flags = {fam_disc, last_dev, disc_pos};
          disc_pos   = TARGET_DISC;
          last_dev   = 1'b0;
          fam_disc   = '0;
          in_verify  = 1'b1;
          alarm      = 1'b0;
        end
        bit_pos  = 7'd1;
        zero_pos = '0;
        crc_run  = '0;
        if (last_dev || !w.present) begin
          r.event_res = EV_DONE;
          r.found     = close_search(1'b0);
        end else begin
          in_search      = 1'b1;
          r.event_res    = EV_CMD;
          r.command_byte = alarm ? CMD_ALARM : CMD_NORMAL;
        end
      end
      OP_BIT_PAIR: begin
        if (in_search) begin
          if (w.id_bit && w.cmp_bit) begin
            r.event_res = EV_DONE;
            r.found     = close_search(1'b0);
          end else begin
            pos = bit_pos[5:0] - 6'd1;
            if (w.id_bit != w.cmp_bit) begin
              dir = w.id_bit;
            end else begin
              // Discrepancy: follow the previous path, take 1 at the last turn, else 0
              if (bit_pos < disc_pos) dir = rom_img[pos];
              else dir = (bit_pos == disc_pos);
              if (!dir) begin
                zero_pos = bit_pos;
                if (zero_pos < FAMILY_LIMIT) fam_disc = zero_pos[3:0];
              end
            end
            rom_img[pos] = dir;
            if (bit_pos[2:0] == 3'd0)
              crc_run = crc8_step(crc_run, rom_img[{pos[5:3], 3'b000} +: 8]);
            bit_pos     = bit_pos + 7'd1;
            r.direction = dir;
            if (bit_pos >= END_INDEX) begin
              r.event_res = EV_DONE;
              r.found     = close_search(1'b1);
            end else begin
              r.event_res = EV_DIR;
            end
          end
        end
      end
      OP_BUS_ERROR: begin
        if (in_search) begin
          r.event_res = EV_DONE;
          r.found     = close_search(1'b0);
        end
      end
      OP_TARGET_SETUP, OP_RESET_SEARCH: begin
        disc_pos  = '0;
        last_dev  = 1'b0;
        fam_disc  = '0;
        rom_img   = '0;
        in_search = 1'b0;
        in_verify = 1'b0;
        if (w.operation == OP_TARGET_SETUP) begin
          rom_img[7:0] = w.family_id;
          disc_pos     = TARGET_DISC;
        end
      end
      default: ;
    endcase
    r.rom_id             = rom_img;
    r.last_device        = last_dev;
    r.family_discrepancy = fam_disc;
  endtask

  // Offer one word, wait for its handshake, then queue its expected result
  task automatic send_word(input owrs_item_t w, input logic typed, input owrs_result_t typed_res);
    owrs_result_t pred;
    int           gap;
    if (idle_on && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 9);
      src_vld <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_word <= w;
    src_vld  <= 1'b1;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    predict_word(w, pred);
    expected_q.push_back(typed ? typed_res : pred);
    if (pred.event_res != EV_ACK || w.operation inside {OP_TARGET_SETUP, OP_RESET_SEARCH})
      n_counted++;
  endtask

  // Hold the sender until every expected result word has come back
  task automatic wait_drained();
    src_vld <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic owrs_item_t mk_item(input logic [2:0] op, input logic al, input logic pr,
                                         input logic id, input logic cm, input logic [7:0] fam);
    return '{op, al, pr, id, cm, fam};
  endfunction

  function automatic owrs_result_t mk_res(input logic [1:0] ev, input logic [7:0] cmd,
                                          input logic dir, input logic fnd,
                                          input logic [63:0] rom);
    return '{ev, cmd, dir, fnd, rom, 1'b0, 4'h0};
  endfunction

  task automatic add_row(input owrs_item_t w, input logic typed, input owrs_result_t r);
    directed_rows.push_back('{w, typed, r});
  endtask

  function automatic owrs_item_t random_word();
    owrs_item_t w;
    w           = owrs_item_t'($urandom());
    w.operation = 3'($urandom_range(0, 7));
    return w;
  endfunction

  // Build a device ROM: random serial, optional shared family, CRC in the top byte; some get a zero family or a bad CRC
  function automatic logic [63:0] make_device(input logic [7:0] fam, input bit use_fam);
    logic [63:0] d;
    logic [7:0]  c;
    int          roll;
    d    = {$urandom(), $urandom()};
    roll = $urandom_range(0, 99);
    if (use_fam) d[7:0] = fam;
    if (roll < 6) d[7:0] = 8'h00;
    c = 8'h00;
    for (int i = 0; i < 7; i++)
      c = crc8_step(c, d[8 * i +: 8]);
    d[63:56] = c;
    if (roll >= 94) d[63:56] = c ^ 8'($urandom_range(1, 255));
    return d;
  endfunction

  task automatic new_bus();
    int         n;
    logic [7:0] fam;
    devices.delete();
    n   = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 4);
    fam = 8'($urandom());
    repeat (n) devices.push_back(make_device(fam, $urandom_range(0, 2) == 0));
  endtask

  // Answer bit pairs as the wired-AND bus would until the search ends
  task automatic walk_search();
    owrs_item_t  w;
    logic [63:0] mask;
    logic        all1;
    logic        all0;
    int          k;
    while (in_search) begin
      if ($urandom_range(0, 99) < 2) begin
        w = random_word();
      end else begin
        w           = random_word();
        w.operation = OP_BIT_PAIR;
        k           = int'(bit_pos) - 1;
        mask        = (64'd1 << k) - 64'd1;
        all1        = 1'b1;
        all0        = 1'b1;
        // Only devices matching the path written so far still talk
        foreach (devices[i]) begin
          if (((devices[i] ^ rom_img) & mask) == 64'd0) begin
            all1 = all1 & devices[i][k];
            all0 = all0 & ~devices[i][k];
          end
        end
        w.id_bit  = all1;
        w.cmp_bit = all0;
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  task automatic start_word(input logic [2:0] op);
    owrs_item_t w;
    w           = random_word();
    w.operation = op;
    w.present   = devices.size() != 0 && $urandom_range(0, 9) != 0;
    send_word(w, 1'b0, '0);
  endtask

  // Main stimulus
  initial begin
    int         roll;
    int         next_phase;
    owrs_item_t w;

    rom_img    = '0;
    disc_pos   = '0;
    last_dev   = 1'b0;
    fam_disc   = '0;
    bit_pos    = 7'd1;
    zero_pos   = '0;
    crc_run    = '0;
    in_search  = 1'b0;
    in_verify  = 1'b0;
    save_rom   = '0;
    save_flags = '0;

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: idle no-ops, restarts, failures, target setup, reset and verify
    add_row(mk_item(OP_BUS_ERROR, 0, 0, 0, 0, 8'h00), 1, mk_res(EV_ACK, 8'h00, 0, 0, 64'h0));
    add_row(mk_item(OP_BIT_PAIR, 0, 0, 1, 0, 8'h00), 1, mk_res(EV_ACK, 8'h00, 0, 0, 64'h0));
    add_row(mk_item(OP_SPARE_6, 0, 0, 0, 0, 8'h00), 1, mk_res(EV_ACK, 8'h00, 0, 0, 64'h0));
    add_row(mk_item(OP_SPARE_7, 1, 1, 1, 1, 8'hFF), 1, mk_res(EV_ACK, 8'h00, 0, 0, 64'h0));
    add_row(mk_item(OP_START, 1, 0, 0, 0, 8'h00), 1, mk_res(EV_DONE, 8'h00, 0, 0, 64'h0));
    add_row(mk_item(OP_START, 1, 1, 0, 0, 8'h00), 1, mk_res(EV_CMD, CMD_ALARM, 0, 0, 64'h0));
    add_row(mk_item(OP_BIT_PAIR, 0, 0, 1, 0, 8'h00), 1, mk_res(EV_DIR, 8'h00, 1, 0, 64'h1));
    add_row(mk_item(OP_BIT_PAIR, 0, 0, 0, 0, 8'h00), 0, '0);
    add_row(mk_item(OP_START, 0, 1, 0, 0, 8'h00), 0, '0);
    add_row(mk_item(OP_BIT_PAIR, 0, 0, 0, 1, 8'h00), 0, '0);
    add_row(mk_item(OP_BUS_ERROR, 0, 0, 0, 0, 8'h00), 1, mk_res(EV_DONE, 8'h00, 0, 0, 64'h0));
    add_row(mk_item(OP_TARGET_SETUP, 1, 1, 1, 1, 8'hFF), 1,
            mk_res(EV_ACK, 8'h00, 0, 0, 64'hFF));
    add_row(mk_item(OP_START, 0, 1, 0, 0, 8'h00), 1, mk_res(EV_CMD, CMD_NORMAL, 0, 0, 64'hFF));
    add_row(mk_item(OP_BIT_PAIR, 0, 0, 1, 1, 8'h00), 1, mk_res(EV_DONE, 8'h00, 0, 0, 64'hFF));
    add_row(mk_item(OP_TARGET_SETUP, 0, 0, 0, 0, 8'h00), 1,
            mk_res(EV_ACK, 8'h00, 0, 0, 64'h0));
    add_row(mk_item(OP_RESET_SEARCH, 1, 1, 1, 1, 8'hFF), 1,
            mk_res(EV_ACK, 8'h00, 0, 0, 64'h0));
    add_row(mk_item(OP_START_VERIFY, 0, 0, 0, 0, 8'h00), 1,
            mk_res(EV_DONE, 8'h00, 0, 0, 64'h0));
    add_row(mk_item(OP_START_VERIFY, 1, 1, 0, 0, 8'h00), 1,
            mk_res(EV_CMD, CMD_NORMAL, 0, 0, 64'h0));
    add_row(mk_item(OP_START, 1, 1, 0, 0, 8'h00), 0, '0);
    add_row(mk_item(OP_START_VERIFY, 0, 1, 0, 0, 8'h00), 0, '0);
    add_row(mk_item(OP_TARGET_SETUP, 0, 0, 0, 0, 8'hA5), 0, '0);
    add_row(mk_item(OP_BUS_ERROR, 0, 0, 0, 0, 8'h00), 0, '0);

    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].r);

    // Random part: searches and verifies over simulated buses, plus target setups, resets and stray words
    new_bus();
    n_counted  = 0;
    next_phase = 0;
    while (n_counted < N_ITEMS) begin
      if (n_counted >= next_phase) begin
        wait_drained();
        idle_on    = (n_counted + PHASE_LEN < N_ITEMS) && $urandom_range(0, 3) != 0;
        next_phase = next_phase + PHASE_LEN;
      end
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        new_bus();
      end else if (roll < 56) begin
        start_word(OP_START);
        walk_search();
      end else if (roll < 74) begin
        start_word(OP_START_VERIFY);
        walk_search();
      end else if (roll < 81) begin
        w           = random_word();
        w.operation = OP_TARGET_SETUP;
        if (devices.size() != 0 && $urandom_range(0, 1) == 1) w.family_id = devices[0][7:0];
        send_word(w, 1'b0, '0);
      end else if (roll < 85) begin
        w           = random_word();
        w.operation = OP_RESET_SEARCH;
        send_word(w, 1'b0, '0);
      end else begin
        send_word(random_word(), 1'b0, '0);
      end
    end

    // Drain, then allow the pipeline latency before the verdict
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
